/* design/cspmg_pkg.sv */
// Shared types and constants for the column suffix max pool with gradient core.
`default_nettype none

package cspmg_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int DATA_BITS   = 32;

    localparam int COL_BITS  = 10;
    localparam int ROW_BITS  = 10;
    localparam int VAL_BITS  = 32;
    localparam int ACC_BITS  = 42;
    localparam int COL_AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    localparam int IN_FIELD_BITS  = COL_BITS + ROW_BITS + 2 * VAL_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = VAL_BITS + ROW_BITS + ACC_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // one accepted input beat
    typedef struct packed {
        logic [COL_BITS-1:0] column;
        logic [ROW_BITS-1:0] row;
        logic [VAL_BITS-1:0] value;
        logic [VAL_BITS-1:0] grad_in;
        logic                first_of_column;
        logic                last_of_column;
    } item_t;

    // per-column state word
    typedef struct packed {
        logic [VAL_BITS-1:0] max;
        logic [ROW_BITS-1:0] max_row;
        logic [ACC_BITS-1:0] acc;
    } entry_t;

    // results of one item: A always, B only when the max moves on the top row
    typedef struct packed {
        logic [VAL_BITS-1:0] pooled;
        logic                a_gv;
        logic [ROW_BITS-1:0] a_row;
        logic [ACC_BITS-1:0] a_sum;
        logic                a_last;
        logic                b_valid;
        logic [ROW_BITS-1:0] b_row;
        logic [ACC_BITS-1:0] b_sum;
    } result_t;

    // keep the low DATA_BITS bits, sign-extended back to full width
    function automatic logic signed [VAL_BITS-1:0] sext_data(input logic [VAL_BITS-1:0] x);
        logic signed [DATA_BITS-1:0] t;
        t = $signed(x[DATA_BITS-1:0]);
        return VAL_BITS'(t);
    endfunction

endpackage

`default_nettype wire

/* design/cspmg_update.sv */
// Per-column update: compare, saturating accumulate and result formation.
`default_nettype none

module cspmg_update (
    input  wire cspmg_pkg::item_t  item,
    input  wire cspmg_pkg::entry_t cur,
    output cspmg_pkg::entry_t  new_entry,
    output logic               wr_en,
    output cspmg_pkg::result_t res
);
    import cspmg_pkg::*;

    logic signed [VAL_BITS-1:0] v;
    logic signed [VAL_BITS-1:0] g;
    logic signed [ACC_BITS-1:0] g_ext;
    logic signed [ACC_BITS:0]   sum_wide;
    logic [ACC_BITS-1:0]        sum_sat;
    logic                       in_range;
    logic                       lastc;

    assign v        = sext_data(item.value);
    assign g        = sext_data(item.grad_in);
    assign g_ext    = ACC_BITS'(g);
    assign sum_wide = (ACC_BITS+1)'($signed(cur.acc)) + (ACC_BITS+1)'(g);
    assign in_range = 32'(item.column) < MAX_COLUMNS;
    assign lastc    = item.last_of_column;

    // clamp when the two top bits disagree
    always_comb
    begin
        if (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1])
        begin
            sum_sat = sum_wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                         : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[ACC_BITS-1:0];
        end
    end

    always_comb
    begin
        res       = '0;
        new_entry = cur;
        wr_en     = in_range;
        res.pooled = cur.max;
        priority if (!in_range)
        begin
            res.pooled = v;
            res.a_last = 1'b1;
        end
        else if (item.first_of_column)
        begin
            new_entry = '{max: v, max_row: item.row, acc: g_ext};
            res.pooled = v;
            res.a_gv   = lastc;
            res.a_row  = lastc ? item.row : '0;
            res.a_sum  = lastc ? g_ext : '0;
            res.a_last = 1'b1;
        end
        else if (v > $signed(cur.max))
        begin
            // max moves up: the old row's sum is finished
            new_entry  = '{max: v, max_row: item.row, acc: g_ext};
            res.pooled = v;
            res.a_gv   = 1'b1;
            res.a_row  = cur.max_row;
            res.a_sum  = cur.acc;
            res.a_last = !lastc;
            res.b_valid = lastc;
            res.b_row  = lastc ? item.row : '0;
            res.b_sum  = lastc ? g_ext : '0;
        end
        else
        begin
            new_entry.acc = sum_sat;
            res.a_gv   = lastc;
            res.a_row  = lastc ? cur.max_row : '0;
            res.a_sum  = lastc ? sum_sat : '0;
            res.a_last = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/column_suffix_max_pool_with_grad_core.sv */
// Top level: column state memory, forwarding and two-result output stage.
//
//  channel  | dir | tdata (low bit first)                 | tuser           | tlast
//  s_axis   | in  | column, row, value, grad_in           | first_of_column | last_of_column
//  m_axis   | out | pooled, grad_row, grad_sum            | grad_valid      | last
//
// One item per cycle sustained while m_axis accepts every beat; an item whose maximum moves on
// the top row gives two beats and holds the output for the second one. An input beat passes
// through the registered memory read, then the update, into the output register.
// The column memory is not cleared at reset; a column is defined once its first row
// has been seen. A write forwards to the next item on the same column.
// Output stalls back up through the update stage to s_axis_tready.
`default_nettype none

module column_suffix_max_pool_with_grad_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // column[9:0], row[19:10], value[51:20], grad_in[83:52], zero pad
    input  wire logic [cspmg_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // first_of_column
    input  wire logic                                s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // pooled[31:0], grad_row[41:32], grad_sum[83:42], zero pad
    output logic [cspmg_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,
    // grad_valid
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import cspmg_pkg::*;

    localparam int ENTRY_BITS = $bits(entry_t);

    logic [ENTRY_BITS-1:0] mem [MAX_COLUMNS];
    logic [ENTRY_BITS-1:0] rdata_reg;

    item_t             in_item;
    item_t             s1_item_reg;
    logic              s1_valid_reg;
    logic [COL_AW-1:0] rd_addr;
    logic [COL_AW-1:0] s1_addr;

    logic              byp_valid_reg;
    logic [COL_AW-1:0] byp_addr_reg;
    entry_t            byp_data_reg;

    entry_t            cur_entry;
    entry_t            new_entry;
    logic              upd_we;
    result_t           upd_res;
    logic              wr_en;

    logic                out_valid_reg;
    logic [VAL_BITS-1:0] out_pooled_reg;
    logic                out_gv_reg;
    logic [ROW_BITS-1:0] out_row_reg;
    logic [ACC_BITS-1:0] out_sum_reg;
    logic                out_last_reg;
    logic                b_valid_reg;
    logic [ROW_BITS-1:0] b_row_reg;
    logic [ACC_BITS-1:0] b_sum_reg;

    logic in_fire;
    logic out_pop;
    logic out_free;
    logic s1_fire;

    assign in_item = '{
        column:          s_axis_tdata[COL_BITS-1:0],
        row:             s_axis_tdata[COL_BITS +: ROW_BITS],
        value:           s_axis_tdata[COL_BITS+ROW_BITS +: VAL_BITS],
        grad_in:         s_axis_tdata[COL_BITS+ROW_BITS+VAL_BITS +: VAL_BITS],
        first_of_column: s_axis_tuser,
        last_of_column:  s_axis_tlast
    };

    assign rd_addr = COL_AW'(in_item.column);
    assign s1_addr = COL_AW'(s1_item_reg.column);

    assign out_pop       = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || (out_pop && !b_valid_reg);
    assign s1_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s1_fire && upd_we;

    // newest write wins over the registered read
    assign cur_entry = (byp_valid_reg && byp_addr_reg == s1_addr) ? byp_data_reg
                                                                  : entry_t'(rdata_reg);

    cspmg_update u_update (
        .item      (s1_item_reg),
        .cur       (cur_entry),
        .new_entry (new_entry),
        .wr_en     (upd_we),
        .res       (upd_res)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[s1_addr] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (wr_en)
            begin
                byp_valid_reg <= 1'b1;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                b_valid_reg   <= upd_res.b_valid;
            end
            else if (out_pop && b_valid_reg)
            begin
                b_valid_reg <= 1'b0;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= new_entry;
        end
        if (s1_fire)
        begin
            out_pooled_reg <= upd_res.pooled;
            out_gv_reg     <= upd_res.a_gv;
            out_row_reg    <= upd_res.a_row;
            out_sum_reg    <= upd_res.a_sum;
            out_last_reg   <= upd_res.a_last;
            b_row_reg      <= upd_res.b_row;
            b_sum_reg      <= upd_res.b_sum;
        end
        else if (out_pop && b_valid_reg)
        begin
            // second beat: final sum of the new maximum row
            out_gv_reg   <= 1'b1;
            out_row_reg  <= b_row_reg;
            out_sum_reg  <= b_sum_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_sum_reg, out_row_reg, out_pooled_reg});
    assign m_axis_tuser  = out_gv_reg;
    assign m_axis_tlast  = out_last_reg;

    a_b_only_after_open_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && b_valid_reg) |-> !out_last_reg)
        else $error("pending second beat behind a beat marked last");

    a_second_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tuser))
        else $error("second beat of an item missing");

    a_no_grad_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_gv_reg) |-> (out_row_reg == '0 && out_sum_reg == '0))
        else $error("gradient fields set without grad_valid");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (byp_valid_reg && byp_addr_reg == $past(s1_addr)))
        else $error("forwarding register lost the last write");

endmodule

`default_nettype wire
